/* hdl/pfl_pkg.sv */
// ----------------------------------------------------------------------------
// Page free list pool package
// Sizes, codes and types shared by the pool core and its checker.
// ----------------------------------------------------------------------------
package pfl_pkg;

  localparam int POOL_COUNT = 2;
  localparam int POOL_DEPTH = 1024;
  localparam int PAGE_BYTES = 4096;

  localparam int AddrW    = 64;
  localparam int RangeW   = 23;
  localparam int PagesW   = 11;
  localparam int ModeW    = 3;
  localparam int PoolW    = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;
  localparam int IdxW     = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CntW     = $clog2(POOL_DEPTH + 1);
  localparam int MemDepth = POOL_COUNT * POOL_DEPTH;
  localparam int MemAW    = $clog2(MemDepth);
  localparam int PageShift = $clog2(PAGE_BYTES);
  localparam int NPagesW  = RangeW - PageShift + 1;
  localparam int WideW    = NPagesW + CntW;

  // stream payload layout
  localparam int InUserW  = ModeW + 1;
  localparam int InDataW  = ((AddrW + RangeW + 7) / 8) * 8;
  localparam int OutUsedW = AddrW + 2 + PagesW;
  localparam int OutDataW = ((OutUsedW + 7) / 8) * 8;

  typedef enum logic [ModeW-1:0] {
    ModePut     = 3'd0,
    ModeGet     = 3'd1,
    ModeGetPhys = 3'd2,
    ModeInit    = 3'd3,
    ModeAvail   = 3'd4
  } mode_e;

  typedef enum logic [0:0] {
    CfgPagingEn = 1'b0,
    CfgOffset   = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    StIdle,
    StGetWait,
    StInit
  } state_e;

  typedef struct packed {
    logic [PagesW-1:0] pages_available;
    logic              overflow;
    logic              was_empty;
    logic [AddrW-1:0]  page_address;
  } result_t;

endpackage

/* hdl/page_free_list_pool_core.sv */
// ----------------------------------------------------------------------------
// Page free list pool core
// FIFO pools of free page addresses kept as rings in one page store memory.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one operation per transaction: tuser holds mode and pool,
//   tdata holds address and range byte count. Every operation returns
//   exactly one result transaction on m_axis (address, empty and overflow
//   flags, page count of the pool after the operation).
//   cfg writes the paging enable (index 0) and translation offset (index 1);
//   it is always ready and must only be written while the core is idle.
// Timing:
//   Put, count and get from an empty pool: result in the cycle after accept,
//   one operation per cycle while the result side is ready. Get: the page
//   store read is registered, then the result is loaded in StGetWait. Init:
//   min(pages, depth) page store writes, one per cycle through the single write port.
//   One operation is in flight at a time, so no store access overlaps.
// Reset: all pools empty, control registers zero; data registers and the page
//   store are not cleared, entries are only read after a put or init wrote them.
// Stall: the result sits in an output register; the next operation is taken
//   in the same cycle the held result is taken.
// ----------------------------------------------------------------------------
module page_free_list_pool_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // cfg
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [0:0]                    cfg_index_i,
  input  logic [pfl_pkg::AddrW-1:0]     cfg_data_i,
  // operations
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [pfl_pkg::InDataW-1:0]   s_axis_tdata,  // address, range_bytes, zero pad
  input  logic [pfl_pkg::InUserW-1:0]   s_axis_tuser,  // mode, pool_select
  // results
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [pfl_pkg::OutDataW-1:0]  m_axis_tdata   // page_address, was_empty,
                                                       // overflow, pages_available, pad
);
  import pfl_pkg::*;

  // configuration registers
  logic             paging_en_q;
  logic [AddrW-1:0] offset_q;
  logic [AddrW-1:0] off_active;

  assign cfg_ready_o = 1'b1;
  assign off_active  = paging_en_q ? offset_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      paging_en_q <= 1'b0;
      offset_q    <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CfgPagingEn: paging_en_q <= cfg_data_i[0];
        CfgOffset:   offset_q    <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  // input decode
  mode_e             in_mode;
  logic [PoolW-1:0]  in_pool;
  logic [AddrW-1:0]  in_addr;
  logic [RangeW-1:0] in_bytes;
  logic              in_fire;

  assign in_mode  = mode_e'(s_axis_tuser[ModeW-1:0]);
  assign in_pool  = (POOL_COUNT > 1) ? PoolW'(s_axis_tuser[ModeW]) : '0;
  assign in_addr  = s_axis_tdata[AddrW-1:0];
  assign in_bytes = s_axis_tdata[AddrW+RangeW-1:AddrW];
  assign in_fire  = s_axis_tvalid && s_axis_tready;

  // init range: page count, wrap check, clipping to the ring depth
  logic [AddrW:0]    range_end;
  logic              range_wraps;
  logic [RangeW:0]   bytes_round;
  logic [NPagesW-1:0] n_pages;
  logic              init_ovf;
  logic [CntW-1:0]   init_store;

  assign range_end   = {1'b0, in_addr} + (AddrW+1)'(in_bytes);
  assign range_wraps = range_end[AddrW];
  assign bytes_round = (RangeW+1)'(in_bytes) + (RangeW+1)'(PAGE_BYTES - 1);
  assign n_pages     = range_wraps ? '0 : bytes_round[RangeW:PageShift];
  assign init_ovf    = WideW'(n_pages) > WideW'(POOL_DEPTH);
  assign init_store  = init_ovf ? CntW'(POOL_DEPTH) : CntW'(n_pages);

  // state
  state_e            state_q, state_d;
  logic [IdxW-1:0]   head_q  [POOL_COUNT];
  logic [IdxW-1:0]   head_d  [POOL_COUNT];
  logic [IdxW-1:0]   tail_q  [POOL_COUNT];
  logic [IdxW-1:0]   tail_d  [POOL_COUNT];
  logic [CntW-1:0]   count_q [POOL_COUNT];
  logic [CntW-1:0]   count_d [POOL_COUNT];
  logic [PoolW-1:0]  pool_q, pool_d;
  logic              phys_q, phys_d;
  logic [AddrW-1:0]  init_val_q, init_val_d;
  logic [CntW-1:0]   init_left_q, init_left_d;
  logic              init_ovf_q, init_ovf_d;

  // output register
  logic              out_valid_q;
  result_t           out_q, out_d;
  logic              out_load;

  // page store
  logic [AddrW-1:0]  mem_q [MemDepth];
  logic [AddrW-1:0]  mem_rdata_q;
  logic              mem_we, mem_re;
  logic [MemAW-1:0]  mem_waddr, mem_raddr;
  logic [AddrW-1:0]  mem_wdata;

  logic [PoolW-1:0]  cur_pool;
  logic [IdxW-1:0]   cur_head, cur_tail;
  logic [CntW-1:0]   cur_count;

  assign cur_pool  = (state_q == StIdle) ? in_pool : pool_q;
  assign cur_head  = head_q[cur_pool];
  assign cur_tail  = tail_q[cur_pool];
  assign cur_count = count_q[cur_pool];

  function automatic logic [IdxW-1:0] idx_inc(input logic [IdxW-1:0] idx);
    return (idx == IdxW'(POOL_DEPTH - 1)) ? '0 : idx + IdxW'(1);
  endfunction

  function automatic logic [MemAW-1:0] mem_index(input logic [PoolW-1:0] pool,
                                                 input logic [IdxW-1:0]  idx);
    return MemAW'(32'(pool) * POOL_DEPTH) + MemAW'(idx);
  endfunction

  // one operation at a time and the result slot is free before accept
  assign s_axis_tready = (state_q == StIdle) && (!out_valid_q || m_axis_tready);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          unique case (in_mode)
            ModeGet, ModeGetPhys: if (cur_count != '0) state_d = StGetWait;
            ModeInit:             if (init_store != '0) state_d = StInit;
            default:              state_d = StIdle;
          endcase
        end
      end
      StGetWait: state_d = StIdle;
      StInit:    if (init_left_q == CntW'(1)) state_d = StIdle;
      default:   state_d = StIdle;
    endcase
  end

  // datapath and pointer updates
  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    pool_d      = pool_q;
    phys_d      = phys_q;
    init_val_d  = init_val_q;
    init_left_d = init_left_q;
    init_ovf_d  = init_ovf_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = mem_index(cur_pool, cur_tail);
    mem_raddr   = mem_index(cur_pool, cur_head);
    mem_wdata   = in_addr - off_active;
    out_load    = 1'b0;
    out_d       = '0;
    out_d.pages_available = PagesW'(cur_count);

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          pool_d = in_pool;
          phys_d = (in_mode == ModeGetPhys);
          unique case (in_mode)
            ModePut: begin
              out_load = 1'b1;
              if (cur_count == CntW'(POOL_DEPTH)) begin
                out_d.overflow = 1'b1;
              end else begin
                mem_we                = 1'b1;
                tail_d[cur_pool]      = idx_inc(cur_tail);
                count_d[cur_pool]     = cur_count + CntW'(1);
                out_d.pages_available = PagesW'(cur_count + CntW'(1));
              end
            end
            ModeGet, ModeGetPhys: begin
              if (cur_count == '0) begin
                out_load           = 1'b1;
                out_d.was_empty    = 1'b1;
                out_d.page_address = (in_mode == ModeGetPhys) ? ~off_active : '1;
              end else begin
                mem_re            = 1'b1;
                head_d[cur_pool]  = idx_inc(cur_head);
                count_d[cur_pool] = cur_count - CntW'(1);
              end
            end
            ModeInit: begin
              head_d[cur_pool]  = '0;
              tail_d[cur_pool]  = '0;
              count_d[cur_pool] = '0;
              init_val_d        = in_addr - off_active;
              init_left_d       = init_store;
              init_ovf_d        = init_ovf;
              if (init_store == '0) begin
                out_load              = 1'b1;
                out_d.pages_available = '0;
              end
            end
            default: out_load = 1'b1;
          endcase
        end
      end
      StGetWait: begin
        out_load           = 1'b1;
        out_d.page_address = phys_q ? mem_rdata_q : mem_rdata_q + off_active;
      end
      StInit: begin
        mem_we            = 1'b1;
        mem_wdata         = init_val_q;
        tail_d[pool_q]    = idx_inc(cur_tail);
        count_d[pool_q]   = cur_count + CntW'(1);
        init_val_d        = init_val_q + AddrW'(PAGE_BYTES);
        init_left_d       = init_left_q - CntW'(1);
        if (init_left_q == CntW'(1)) begin
          out_load              = 1'b1;
          out_d.overflow        = init_ovf_q;
          out_d.pages_available = PagesW'(cur_count + CntW'(1));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      pool_q      <= '0;
      phys_q      <= 1'b0;
      init_left_q <= '0;
      init_ovf_q  <= 1'b0;
      for (int i = 0; i < POOL_COUNT; i++) begin
        head_q[i]  <= '0;
        tail_q[i]  <= '0;
        count_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      pool_q      <= pool_d;
      phys_q      <= phys_d;
      init_left_q <= init_left_d;
      init_ovf_q  <= init_ovf_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    init_val_q <= init_val_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  // page store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem_q[mem_raddr];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'(out_q);

endmodule

/* hdl/pfl_checker.sv */
// ----------------------------------------------------------------------------
// Page free list pool checker
// Port-level assertions on the pool core, bound to its top level.
// ----------------------------------------------------------------------------
module pfl_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [pfl_pkg::OutDataW-1:0]  m_axis_tdata
);
  import pfl_pkg::*;

  logic              res_empty;
  logic              res_ovf;
  logic [PagesW-1:0] res_pages;

  assign res_empty = m_axis_tdata[AddrW];
  assign res_ovf   = m_axis_tdata[AddrW+1];
  assign res_pages = m_axis_tdata[AddrW+2+PagesW-1:AddrW+2];

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // no new operation while a held result blocks the output slot
  a_no_accept_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("operation taken while result stalled");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res_empty |-> res_pages == '0)
    else $error("empty get with nonzero page count");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(res_empty && res_ovf))
    else $error("empty and overflow both set");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res_ovf |-> res_pages == PagesW'(POOL_DEPTH))
    else $error("overflow with pool not full");

endmodule

bind page_free_list_pool_core pfl_checker u_pfl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* tb/tb_page_free_list_pool_core.sv */
// ----------------------------------------------------------------------------
// Page free list pool core testbench
// Drives put, get, get-physical, init, count and spare-mode operations on both pools.
// Settings cover paging off and on and offsets of zero, all ones and random.
// A scoreboard keeps its own rings per pool and checks every result in order.
// Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_page_free_list_pool_core;
  timeunit 1ns;
  timeprecision 1ps;

  import pfl_pkg::*;

  localparam logic [ModeW-1:0] ModeTop = '1;
  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned MaxReports = 100;

  typedef struct {
    logic [ModeW-1:0]  mode;
    logic              pool;
    logic [AddrW-1:0]  addr;
    logic [RangeW-1:0] bytes;
  } pool_op_t;

  class pool_scoreboard;
    logic [AddrW-1:0] ring [POOL_COUNT][POOL_DEPTH];
    int unsigned head [POOL_COUNT];
    int unsigned tail [POOL_COUNT];
    int unsigned level [POOL_COUNT];
    logic paging;
    logic [AddrW-1:0] offset;
    result_t results_due [$];
    int unsigned errors, checked, n_ops, n_inits, n_empty, n_dropped;

    function new();
      paging = 1'b0;
      offset = '0;
    endfunction

    function logic [AddrW-1:0] xlate();
      return paging ? offset : '0;
    endfunction

    // returns 1 when the pool is full and the page is dropped
    function bit push_page(int p, logic [AddrW-1:0] a);
      if (level[p] >= POOL_DEPTH) return 1'b1;
      ring[p][tail[p]] = a - xlate();
      tail[p] = (tail[p] + 1) % POOL_DEPTH;
      level[p]++;
      return 1'b0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [AddrW-1:0] val);
      case (idx)
        CfgPagingEn: paging = val[0];
        CfgOffset:   offset = val;
        default: ;
      endcase
    endfunction

    function void predict_pool_op(pool_op_t op);
      result_t r;
      int p;
      int unsigned n_pages;
      logic [AddrW-1:0] off, v;
      logic [AddrW:0] span_end;
      r = '0;
      p = int'(op.pool) % POOL_COUNT;
      off = xlate();
      n_ops++;
      case (op.mode)
        ModePut: r.overflow = push_page(p, op.addr);
        ModeGet, ModeGetPhys: begin
          if (level[p] == 0) begin
            r.was_empty = 1'b1;
            v = '1;
          end else begin
            v = ring[p][head[p]] + off;
            head[p] = (head[p] + 1) % POOL_DEPTH;
            level[p]--;
          end
          r.page_address = (op.mode == ModeGetPhys) ? v - off : v;
        end
        ModeInit: begin
          n_inits++;
          head[p] = 0;
          tail[p] = 0;
          level[p] = 0;
          span_end = {1'b0, op.addr} + (AddrW+1)'(op.bytes);
          if (!span_end[AddrW]) begin
            n_pages = (int'(op.bytes) + PAGE_BYTES - 1) / PAGE_BYTES;
            for (int k = 0; k < n_pages; k++) begin
              if (push_page(p, op.addr + 64'(k) * 64'(PAGE_BYTES))) begin
                r.overflow = 1'b1;
                break;
              end
            end
          end
        end
        default: ;  // count and the spare modes only report the level
      endcase
      r.pages_available = PagesW'(level[p]);
      if (r.was_empty) n_empty++;
      if (r.overflow) n_dropped++;
      results_due.push_back(r);
    endfunction

    function void flag_mismatch(string field, logic [AddrW-1:0] e, logic [AddrW-1:0] g);
      errors++;
      if (errors <= MaxReports)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, e, g);
    endfunction

    function void check_result(result_t got);
      result_t e;
      if (results_due.size() == 0) begin
        errors++;
        $display("%0t: result transaction with nothing outstanding, page_address %0h",
                 $time, got.page_address);
        return;
      end
      e = results_due.pop_front();
      checked++;
      if (got.page_address !== e.page_address)
        flag_mismatch("page_address", e.page_address, got.page_address);
      if (got.was_empty !== e.was_empty)
        flag_mismatch("was_empty", 64'(e.was_empty), 64'(got.was_empty));
      if (got.overflow !== e.overflow)
        flag_mismatch("overflow", 64'(e.overflow), 64'(got.overflow));
      if (got.pages_available !== e.pages_available)
        flag_mismatch("pages_available", 64'(e.pages_available), 64'(got.pages_available));
    endfunction

    function int pending();
      return results_due.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [0:0]          cfg_index_i = CfgPagingEn;
  logic [AddrW-1:0]    cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;   // address, range_bytes, pad
  logic [InUserW-1:0]  s_axis_tuser = '0;   // mode, pool_select
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;        // page_address, was_empty, overflow,
                                            // pages_available, pad

  pool_scoreboard sb = new();
  bit no_idle = 1'b0;
  int unsigned rx_hold = 0;
  int unsigned stall_cycles = 0;
  int unsigned n_settings = 0;

  page_free_list_pool_core u_top (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    if ($urandom_range(0, 19) < 17) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk_i) begin
    if (rx_hold != 0) begin
      m_axis_tready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if (!no_idle && $urandom_range(0, 3) == 0) rx_hold <= idle_len();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(result_t'(m_axis_tdata[OutUsedW-1:0]));
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == WatchdogLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, WatchdogLimit);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [AddrW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_regs(logic [AddrW-1:0] paging_word, logic [AddrW-1:0] offset);
    write_reg(CfgPagingEn, paging_word);
    write_reg(CfgOffset, offset);
    n_settings++;
  endtask

  task automatic send_op(pool_op_t op);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDataW'({op.bytes, op.addr});
    s_axis_tuser  <= {op.pool, op.mode};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.predict_pool_op(op);
  endtask

  task automatic send_gapped(pool_op_t op);
    int unsigned gap;
    gap = (!no_idle && $urandom_range(0, 2) == 0) ? idle_len() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    send_op(op);
  endtask

  // sender holds off until every outstanding result is back
  task automatic wait_pools_quiet();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic pool_op_t mk_op(logic [ModeW-1:0] mode, logic pool,
                                     logic [AddrW-1:0] addr, logic [RangeW-1:0] bytes);
    pool_op_t op;
    op.mode = mode;
    op.pool = pool;
    op.addr = addr;
    op.bytes = bytes;
    return op;
  endfunction

  function automatic pool_op_t random_op();
    pool_op_t op;
    int unsigned r;
    r = $urandom_range(0, 99);
    op.pool  = 1'($urandom_range(0, 1));
    op.addr  = {$urandom, $urandom};
    op.bytes = RangeW'($urandom);
    if (r < 40) begin
      op.mode = ModePut;
      if ($urandom_range(0, 1) == 0) op.addr[PageShift-1:0] = '0;
    end else if (r < 62) begin
      op.mode = ModeGet;
    end else if (r < 74) begin
      op.mode = ModeGetPhys;
    end else if (r < 82) begin
      op.mode = ModeAvail;
    end else if (r < 88) begin
      op.mode = ModeW'($urandom_range(int'(ModeAvail) + 1, int'(ModeTop)));
    end else begin
      op.mode = ModeInit;
      case ($urandom_range(0, 9))
        0: ;  // full 23-bit size, can run past the pool depth
        1: begin
          // base near the top of the address space, may wrap
          op.addr  = '1 - AddrW'($urandom_range(0, 65535));
          op.bytes = RangeW'($urandom_range(0, 131071));
        end
        default: op.bytes = RangeW'($urandom_range(0, 12 * PAGE_BYTES));
      endcase
    end
    return op;
  endfunction

  task automatic run_directed();
    pool_op_t ops [$];
    ops.push_back(mk_op(ModeGet, 1'b0, '0, '0));
    ops.push_back(mk_op(ModeGetPhys, 1'b0, '0, '0));
    ops.push_back(mk_op(ModePut, 1'b0, '0, '0));
    ops.push_back(mk_op(ModePut, 1'b0, '1, '1));
    ops.push_back(mk_op(ModeAvail, 1'b0, '0, '0));
    ops.push_back(mk_op(ModeGet, 1'b0, '0, '0));
    ops.push_back(mk_op(ModeGetPhys, 1'b0, '0, '0));
    ops.push_back(mk_op(ModeInit, 1'b1, {$urandom, $urandom}, '0));
    ops.push_back(mk_op(ModeInit, 1'b1, '0, 23'd1));
    ops.push_back(mk_op(ModeInit, 1'b1, 64'h1000, 23'(3 * PAGE_BYTES + 1)));
    ops.push_back(mk_op(ModeGet, 1'b1, '0, '0));
    ops.push_back(mk_op(ModeInit, 1'b1, '1 - 64'd100, 23'd200));
    ops.push_back(mk_op(ModeInit, 1'b1, '1 - 64'd8192, 23'd8192));
    ops.push_back(mk_op(ModeGetPhys, 1'b1, '0, '0));
    ops.push_back(mk_op(ModeInit, 1'b0, {$urandom, $urandom}, '1));
    ops.push_back(mk_op(ModePut, 1'b0, {$urandom, $urandom}, '0));
    ops.push_back(mk_op(ModeAvail + 3'd1, 1'b0, '0, '0));
    ops.push_back(mk_op(ModeAvail + 3'd2, 1'b1, '1, '1));
    ops.push_back(mk_op(ModeTop, 1'b0, '0, '0));
    // exactly the pool depth in pages, fits without a drop
    ops.push_back(mk_op(ModeInit, 1'b0, {$urandom, 32'h0}, 23'(POOL_DEPTH * PAGE_BYTES)));
    ops.push_back(mk_op(ModeGetPhys, 1'b0, '0, '0));
    ops.push_back(mk_op(ModePut, 1'b0, {$urandom, $urandom}, '0));
    ops.push_back(mk_op(ModeInit, 1'b0, '0, '0));
    foreach (ops[i]) send_gapped(ops[i]);
  endtask

  task automatic run_random(int unsigned n_items);
    repeat (n_items) send_gapped(random_op());
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_regs({$urandom, $urandom} | 64'd1, {$urandom, $urandom});
    run_directed();
    wait_pools_quiet();

    set_regs(64'd1, {$urandom, $urandom});
    run_random(230);
    wait_pools_quiet();

    set_regs({$urandom, $urandom} | 64'd1, '1);
    run_random(230);
    wait_pools_quiet();

    // paging off: the offset must be ignored
    set_regs({$urandom, $urandom} & ~64'd1, '1);
    run_random(230);
    wait_pools_quiet();

    no_idle = 1'b1;
    set_regs(64'd1, '0);
    run_random(230);
    wait_pools_quiet();

    no_idle = 1'b0;
    set_regs(64'd1, {$urandom, $urandom} << PageShift);
    run_random(230);
    wait_pools_quiet();

    repeat (20) @(posedge clk_i);

    $display("Covered %0d operations (%0d inits) under %0d register settings.",
             sb.n_ops, sb.n_inits, n_settings);
    $display("%0d results checked, %0d empty gets, %0d dropped puts or inits.",
             sb.checked, sb.n_empty, sb.n_dropped);
    if (sb.pending() != 0)
      $display("%0t: %0d results never arrived", $time, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/pfl_pkg.sv
hdl/page_free_list_pool_core.sv
hdl/pfl_checker.sv
tb/tb_page_free_list_pool_core.sv
